// ===== hw/rtl/pp2rgb_pkg.sv =====
// Shared types and constants for the packed pixel to RGB24 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pp2rgb_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_MODE,
    REG_BGR_SWAP
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_YUYV,
    MODE_RGB555,
    MODE_RGB565,
    MODE_RGB24
  } mode_t;

  // BT.601 chroma coefficients, scaled by 1000
  localparam int K_RV = 1402;
  localparam int K_GU = 344;
  localparam int K_GV = 714;
  localparam int K_BU = 1772;

  localparam int PROD_W = 18;   // 1772 * 127 fits in 18 bits
  // floor(p / 1000) == (p * RECIP_1000) >> RECIP_SHIFT for all p < 2**18
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_1000  = 268436;
  localparam int RECIP_W     = 19;
  localparam int WIDE_W      = PROD_W + RECIP_W;

  // item as it enters the pipeline, with the mode it was taken under
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       fend;
    mode_t      mode;
    logic       swap;
  } src_t;

  // signed chroma offsets for red, green (subtracted) and blue
  typedef struct packed {
    logic signed [8:0] dr;
    logic signed [8:0] dg;
    logic signed [8:0] db;
  } off_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // one or two finished pixels of an item
  typedef struct packed {
    rgb_t px0;
    rgb_t px1;
    logic two;
    logic fend;
  } pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pp2rgb_chroma_scale.sv =====
// Three-stage chroma path: centre/saturate, coefficient products, divide by 1000.
// Depends on pp2rgb_pkg.
`default_nettype none

module pp2rgb_chroma_scale (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pp2rgb_pkg::src_t   in_src,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pp2rgb_pkg::src_t        out_src,
  output pp2rgb_pkg::off_t        out_off
);
  import pp2rgb_pkg::*;

  logic              v1, v2, v3;
  logic              ready1, ready2, ready3;
  src_t              src1, src2, src3;
  logic              neg_u1, neg_v1, neg_u2, neg_v2;
  logic [6:0]        mag_u1, mag_v1;
  logic [6:0]        mag_u_next, mag_v_next;
  logic [PROD_W-1:0] pr2, pgu2, pgv2, pb2;
  logic [7:0]        qr, qgu, qgv, qb;
  logic signed [9:0] sr, sgu, sgv, sb, sg;
  off_t              off3;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // magnitude of byte - 128, saturated to 127
  always_comb begin
    if (in_src.b1[7]) mag_u_next = in_src.b1[6:0];
    else if (in_src.b1 == 8'd0) mag_u_next = 7'd127;
    else mag_u_next = 7'(8'd128 - in_src.b1);
    if (in_src.b3[7]) mag_v_next = in_src.b3[6:0];
    else if (in_src.b3 == 8'd0) mag_v_next = 7'd127;
    else mag_v_next = 7'(8'd128 - in_src.b3);
  end

  function automatic logic [7:0] div1000(input logic [PROD_W-1:0] p);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(p) * WIDE_W'(RECIP_1000);
    return 8'(w >> RECIP_SHIFT);
  endfunction

  assign qr  = div1000(pr2);
  assign qgu = div1000(pgu2);
  assign qgv = div1000(pgv2);
  assign qb  = div1000(pb2);

  always_comb begin
    sr  = neg_v2 ? -$signed({2'b00, qr})  : $signed({2'b00, qr});
    sgu = neg_u2 ? -$signed({2'b00, qgu}) : $signed({2'b00, qgu});
    sgv = neg_v2 ? -$signed({2'b00, qgv}) : $signed({2'b00, qgv});
    sb  = neg_u2 ? -$signed({2'b00, qb})  : $signed({2'b00, qb});
    sg  = sgu + sgv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      src1   <= in_src;
      neg_u1 <= !in_src.b1[7];
      neg_v1 <= !in_src.b3[7];
      mag_u1 <= mag_u_next;
      mag_v1 <= mag_v_next;
    end
    if (ready2) begin
      src2   <= src1;
      neg_u2 <= neg_u1;
      neg_v2 <= neg_v1;
      pr2    <= PROD_W'(mag_v1) * PROD_W'(K_RV);
      pgu2   <= PROD_W'(mag_u1) * PROD_W'(K_GU);
      pgv2   <= PROD_W'(mag_v1) * PROD_W'(K_GV);
      pb2    <= PROD_W'(mag_u1) * PROD_W'(K_BU);
    end
    if (ready3) begin
      src3    <= src2;
      off3.dr <= sr[8:0];
      off3.dg <= sg[8:0];
      off3.db <= sb[8:0];
    end
  end

  assign out_valid = v3;
  assign out_src   = src3;
  assign out_off   = off3;

endmodule

`default_nettype wire

// ===== hw/rtl/pp2rgb_pixel_form.sv =====
// Pixel stage: luma plus offsets with clamping, RGB555/565 expansion, RGB24 pass.
// Depends on pp2rgb_pkg.
`default_nettype none

module pp2rgb_pixel_form (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pp2rgb_pkg::src_t   in_src,
  input  wire pp2rgb_pkg::off_t   in_off,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pp2rgb_pkg::pair_t       out_pair
);
  import pp2rgb_pkg::*;

  logic  v4;
  pair_t pair4, pair_next;

  function automatic logic [7:0] clamp_add(input logic [7:0] y, input logic signed [8:0] d,
                                           input logic sub);
    logic signed [9:0] s;
    s = sub ? $signed({2'b00, y}) - 10'(d) : $signed({2'b00, y}) + 10'(d);
    if (s < 0) return 8'd0;
    else if (s > 10'sd255) return 8'd255;
    else return s[7:0];
  endfunction

  always_comb begin
    pair_next      = '0;
    pair_next.fend = in_src.fend;
    case (in_src.mode)
      MODE_YUYV: begin
        pair_next.two   = 1'b1;
        pair_next.px0.r = clamp_add(in_src.b0, in_off.dr, 1'b0);
        pair_next.px0.g = clamp_add(in_src.b0, in_off.dg, 1'b1);
        pair_next.px0.b = clamp_add(in_src.b0, in_off.db, 1'b0);
        pair_next.px1.r = clamp_add(in_src.b2, in_off.dr, 1'b0);
        pair_next.px1.g = clamp_add(in_src.b2, in_off.dg, 1'b1);
        pair_next.px1.b = clamp_add(in_src.b2, in_off.db, 1'b0);
      end
      MODE_RGB555: begin
        pair_next.px0.b = {in_src.b0[4:0], 3'b000};
        pair_next.px0.g = {in_src.b1[1:0], in_src.b0[7:5], 3'b000};
        pair_next.px0.r = {in_src.b1[6:2], 3'b000};
      end
      MODE_RGB565: begin
        pair_next.px0.b = {in_src.b0[4:0], 3'b000};
        pair_next.px0.g = {in_src.b1[2:0], in_src.b0[7:5], 2'b00};
        pair_next.px0.r = {in_src.b1[7:3], 3'b000};
      end
      MODE_RGB24: begin
        pair_next.px0.g = in_src.b1;
        pair_next.px0.r = in_src.swap ? in_src.b2 : in_src.b0;
        pair_next.px0.b = in_src.swap ? in_src.b0 : in_src.b2;
      end
      default: pair_next = '0;
    endcase
  end

  assign in_ready = !v4 || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (in_ready) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) pair4 <= pair_next;
  end

  assign out_valid = v4;
  assign out_pair  = pair4;

endmodule

`default_nettype wire

// ===== hw/rtl/pp2rgb_serializer.sv =====
// Output register: sends one or two pixels of an item, one pixel per handshake.
// Depends on pp2rgb_pkg.
`default_nettype none

module pp2rgb_serializer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pp2rgb_pkg::pair_t  in_pair,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pp2rgb_pkg::rgb_t        out_pixel,
  output logic                    out_last_run,
  output logic                    out_fend
);
  import pp2rgb_pkg::*;

  logic  full;
  logic  phase;    // first pixel of a two-pixel item already sent
  pair_t pair_q;
  logic  first_beat;
  logic  done;

  assign first_beat   = pair_q.two && !phase;
  assign out_valid    = full;
  assign out_pixel    = (pair_q.two && phase) ? pair_q.px1 : pair_q.px0;
  assign out_last_run = !first_beat;
  assign out_fend     = !first_beat && pair_q.fend;
  assign done         = full && out_ready && !first_beat;
  assign in_ready     = !full || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      phase <= 1'b0;
    end else if (in_ready) begin
      full  <= in_valid;
      phase <= 1'b0;
    end else if (full && out_ready) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) pair_q <= in_pair;
  end

`ifndef SYNTH
  a_phase_only_two : assert property (@(posedge clk) disable iff (rst)
    phase |-> (full && pair_q.two))
    else $error("second-pixel phase without a two-pixel item");

  a_second_follows : assert property (@(posedge clk) disable iff (rst)
    (full && first_beat && out_ready) |=> (full && phase))
    else $error("second pixel did not follow the first");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    (done && !in_valid) |=> !full)
    else $error("item still held after its last pixel");

  a_new_item_fresh : assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid) |=> (full && !phase))
    else $error("new item did not start at its first pixel");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/packed_pixel_to_rgb24_converter_core.sv =====
// Top level of the packed pixel to RGB24 converter.
// Depends on pp2rgb_pkg, pp2rgb_chroma_scale, pp2rgb_pixel_form, pp2rgb_serializer.
//
// Usage:
//   s_* carries one source item per handshake (four bytes in tdata, frame end in
//   tlast). m_* carries one RGB24 pixel per handshake. YUYV items give two
//   pixels, other modes one. The cfg port writes pixel_mode (index 0) and
//   bgr_swap (index 1); write it only while the block is idle.
// Pipeline: an accepted item passes four pipeline registers and the output register
//   before its first pixel is presented.
// Throughput: one item per cycle in RGB modes while m_tready stays high; in YUYV
//   mode each item gives two pixels to the single-pixel output channel, which limits the item rate.
// Reset: rst clears all valid bits and sets pixel_mode to YUYV, bgr_swap to 0.
// Stall: when m_tready is low, each pipeline register fills in turn and
//   s_tready drops once all are full; nothing is dropped or repeated.
`default_nettype none

module packed_pixel_to_rgb24_converter_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pp2rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pp2rgb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [31:0]                         s_tdata,  // byte_zero..byte_three
  input  wire logic                                s_tlast,  // frame_end_in
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [23:0]                              m_tdata,  // red, green, blue
  output logic                                     m_tuser,  // last_of_run
  output logic                                     m_tlast   // frame_end_out
);
  import pp2rgb_pkg::*;

  mode_t pixel_mode;
  logic  bgr_swap;

  src_t  in_src, cs_src;
  off_t  cs_off;
  pair_t pf_pair;
  rgb_t  px;
  logic  cs_valid, cs_ready, pf_valid, pf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= MODE_YUYV;
      bgr_swap   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PIXEL_MODE: pixel_mode <= mode_t'(cfg_data[1:0]);
        REG_BGR_SWAP:   bgr_swap   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_src.b0   = s_tdata[7:0];
    in_src.b1   = s_tdata[15:8];
    in_src.b2   = s_tdata[23:16];
    in_src.b3   = s_tdata[31:24];
    in_src.fend = s_tlast;
    in_src.mode = pixel_mode;
    in_src.swap = bgr_swap;
  end

  pp2rgb_chroma_scale u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_src    (in_src),
    .out_valid (cs_valid),
    .out_ready (cs_ready),
    .out_src   (cs_src),
    .out_off   (cs_off)
  );

  pp2rgb_pixel_form u_form (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cs_valid),
    .in_ready  (cs_ready),
    .in_src    (cs_src),
    .in_off    (cs_off),
    .out_valid (pf_valid),
    .out_ready (pf_ready),
    .out_pair  (pf_pair)
  );

  pp2rgb_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pf_valid),
    .in_ready     (pf_ready),
    .in_pair      (pf_pair),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_pixel    (px),
    .out_last_run (m_tuser),
    .out_fend     (m_tlast)
  );

  assign m_tdata = {px.b, px.g, px.r};

endmodule

`default_nettype wire

// ===== tb/tb_packed_pixel_to_rgb24_converter_core.sv =====
// Self-checking testbench for packed_pixel_to_rgb24_converter_core.
// Needs pp2rgb_pkg and the core RTL. A scoreboard class predicts every pixel
// and checks the master stream against it.
`default_nettype none

module tb_packed_pixel_to_rgb24_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pp2rgb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       frame_end;
  } rgb_px_t;

  class pixel_scoreboard;
    mode_t   mode;
    bit      swap;
    rgb_px_t pixel_q[$];
    int      fails;

    function new();
      mode  = MODE_YUYV;
      swap  = 1'b0;
      fails = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIXEL_MODE: mode = mode_t'(data);
        REG_BGR_SWAP:   swap = data[0];
        default: ;
      endcase
    endfunction

    // centered chroma, saturated to -127..127
    static function int chroma(logic [7:0] b);
      int c;
      c = int'(b) - 128;
      if (c < -127) c = -127;
      return c;
    endfunction

    static function logic [7:0] sat8(int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return x[7:0];
    endfunction

    function void note_input(logic [31:0] data, logic fend);
      logic [7:0] b0, b1, b2;
      int u, v, y1, y2, dr, dg, db;
      rgb_px_t px;
      b0 = data[7:0];
      b1 = data[15:8];
      b2 = data[23:16];
      px.last_of_run = 1'b1;
      px.frame_end   = fend;
      case (mode)
        MODE_YUYV: begin
          u  = chroma(b1);
          v  = chroma(data[31:24]);
          y1 = int'(b0);
          y2 = int'(b2);
          // each product is divided on its own, truncating toward zero
          dr = (1402 * v) / 1000;
          dg = (344 * u) / 1000 + (714 * v) / 1000;
          db = (1772 * u) / 1000;
          pixel_q.push_back({sat8(y1 + dr), sat8(y1 - dg), sat8(y1 + db), 1'b0, 1'b0});
          px.red   = sat8(y2 + dr);
          px.green = sat8(y2 - dg);
          px.blue  = sat8(y2 + db);
        end
        MODE_RGB555: begin
          px.red   = {b1[6:2], 3'b000};
          px.green = {b1[1:0], b0[7:5], 3'b000};
          px.blue  = {b0[4:0], 3'b000};
        end
        MODE_RGB565: begin
          px.red   = {b1[7:3], 3'b000};
          px.green = {b1[2:0], b0[7:5], 2'b00};
          px.blue  = {b0[4:0], 3'b000};
        end
        default: begin
          px.red   = swap ? b2 : b0;
          px.green = b1;
          px.blue  = swap ? b0 : b2;
        end
      endcase
      pixel_q.push_back(px);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("%s expected %0d got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [23:0] data, logic user, logic last);
      rgb_px_t px;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel %h (last_of_run %0b frame_end %0b)", data, user, last);
        fails++;
        return;
      end
      px = pixel_q.pop_front();
      compare("red", px.red, data[7:0]);
      compare("green", px.green, data[15:8]);
      compare("blue", px.blue, data[23:16]);
      compare("last_of_run", px.last_of_run, user);
      compare("frame_end_out", px.frame_end, last);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;  // byte_zero, byte_one, byte_two, byte_three
  logic                  s_tlast;  // frame_end_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;  // red, green, blue
  logic                  m_tuser;  // last_of_run
  logic                  m_tlast;  // frame_end_out

  pixel_scoreboard sb = new();
  bit hold_off_req;

  packed_pixel_to_rgb24_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // receiver: random stall styles in segments, plus one long hold-off on request
  initial begin : receiver
    int style;
    int seg;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        seg   = $urandom_range(8, 64);
        repeat (seg) begin
          @(negedge clk);
          case (style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                           logic fend);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {b3, b2, b1, b0};
    s_tlast  <= fend;
    do @(posedge clk); while (!s_tready);
    sb.note_input({b3, b2, b1, b0}, fend);
  endtask

  task automatic idle(int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait out all pixels, then a few cycles so the pipeline is empty
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd129;
      5: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic send_random(int count, bit gappy);
    int burst_left;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        if (gappy) idle($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      send_item(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                $urandom_range(0, 7) == 0);
      burst_left--;
    end
    idle(1);
  endtask

  initial begin : stimulus
    mode_t m;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // yuyv from reset: chroma extremes, zero chroma, byte 1 saturating like 0
    send_item(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
    send_item(8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
    send_item(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    send_item(8'd16, 8'd1, 8'd235, 8'd1, 1'b0);
    send_item(8'd200, 8'd127, 8'd50, 8'd129, 1'b0);
    send_item(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
    send_item(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_item(8'd90, 8'd200, 8'd170, 8'd60, 1'b0);
    idle(1);
    drain();

    write_reg(REG_PIXEL_MODE, MODE_RGB555);
    send_item(8'hff, 8'hff, 8'h00, 8'h00, 1'b0);
    send_item(8'h00, 8'h00, 8'hff, 8'hff, 1'b0);
    send_item(8'h5a, 8'ha5, 8'h33, 8'hcc, 1'b1);
    idle(1);
    drain();

    write_reg(REG_PIXEL_MODE, MODE_RGB565);
    send_item(8'hff, 8'hff, 8'h00, 8'h00, 1'b0);
    send_item(8'h1f, 8'he0, 8'hff, 8'hff, 1'b1);
    send_item(8'ha5, 8'h5a, 8'h33, 8'hcc, 1'b0);
    idle(1);
    drain();

    write_reg(REG_PIXEL_MODE, MODE_RGB24);
    send_item(8'h11, 8'h22, 8'h33, 8'hff, 1'b1);
    idle(1);
    drain();
    // swap written with an out-of-range value: only bit 0 counts
    write_reg(REG_BGR_SWAP, 2'd3);
    send_item(8'hff, 8'h00, 8'h80, 8'h00, 1'b0);
    send_item(8'h01, 8'h02, 8'h03, 8'h00, 1'b1);
    idle(1);
    drain();
    write_reg(REG_BGR_SWAP, 2'd2);
    send_item(8'hff, 8'h00, 8'h80, 8'h00, 1'b0);
    idle(1);
    drain();

    for (int p = 0; p < 10; p++) begin
      m = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
      write_reg(REG_PIXEL_MODE, m);
      write_reg(REG_BGR_SWAP, 2'($urandom_range(0, 3)));
      if (p == 5) begin
        // long output stall while the sender keeps pushing back-to-back
        hold_off_req = 1'b1;
        send_random(95, 1'b0);
      end else begin
        send_random(95, p != 2);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
